@@ hdl/rrtt_pkg.sv @@
// Shared types and codes for the round-robin task table.
// No dependencies; used by rrtt_slot_eval and round_robin_task_table_core.
package rrtt_pkg;

    typedef enum logic [2:0] {
        ST_UNUSED  = 3'd0,
        ST_READY   = 3'd1,
        ST_RUNNING = 3'd2,
        ST_BLOCKED = 3'd3,
        ST_ZOMBIE  = 3'd4,
        ST_DEAD    = 3'd5
    } t_slot_state;

    typedef enum logic [2:0] {
        F_SPAWN_KERNEL = 3'd0,
        F_SPAWN_USER   = 3'd1,
        F_FORK         = 3'd2,
        F_YIELD        = 3'd3,
        F_EXIT         = 3'd4,
        F_WAIT         = 3'd5,
        F_TICK         = 3'd6,
        F_IRQ_RETURN   = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        RS_OK           = 3'd0,
        RS_NO_SLOT      = 3'd1,
        RS_ALLOC_FAIL   = 3'd2,
        RS_NO_CHILD     = 3'd3,
        RS_BLOCKED      = 3'd4,
        RS_NOTHING_RUN  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        SCAN_FREE,
        SCAN_PARENT,
        SCAN_CHILD,
        SCAN_READY,
        SCAN_ALIVE
    } t_scan_mode;

    typedef struct packed {
        logic hit;
        logic zombie;
        logic blocked;
        logic live;
    } t_eval;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPAWN_SCAN,
        S_EXIT_WR,
        S_EXIT_SCAN,
        S_WAIT_SCAN,
        S_WAIT_BLOCK,
        S_PICK,
        S_MOVE_OUT,
        S_MOVE_IN,
        S_COUNT,
        S_DONE
    } t_seq_state;

    localparam logic CFG_PREEMPT = 1'b0;
    localparam logic CFG_QUANTUM = 1'b1;

    localparam int CFG_W = 8;
    localparam int STATUS_W = 3;
    localparam int EXIT_W = 32;
    localparam int SLICE_W = 8;

endpackage

@@ hdl/rrtt_slot_eval.sv @@
// Shared slot compare unit: tests one table slot against the scan mode.
// Depends on rrtt_pkg.
module rrtt_slot_eval #(
    parameter int PID_BITS = 16
) (
    input  rrtt_pkg::t_scan_mode  i_mode,
    input  rrtt_pkg::t_slot_state i_state,
    input  logic [PID_BITS-1:0]   i_pid,
    input  logic [PID_BITS-1:0]   i_parent,
    input  logic [PID_BITS-1:0]   i_key,
    output rrtt_pkg::t_eval       o_eval
);

    logic used;

    always_comb begin
        used = (i_state != rrtt_pkg::ST_UNUSED);
        o_eval.zombie  = (i_state == rrtt_pkg::ST_ZOMBIE);
        o_eval.blocked = (i_state == rrtt_pkg::ST_BLOCKED);
        o_eval.live    = (i_state == rrtt_pkg::ST_RUNNING) || (i_state == rrtt_pkg::ST_READY);
        case (i_mode)
            rrtt_pkg::SCAN_FREE:   o_eval.hit = !used;
            rrtt_pkg::SCAN_PARENT: o_eval.hit = used && (i_pid == i_key);
            rrtt_pkg::SCAN_CHILD:  o_eval.hit = used && (i_parent == i_key);
            rrtt_pkg::SCAN_READY:  o_eval.hit = (i_state == rrtt_pkg::ST_READY);
            rrtt_pkg::SCAN_ALIVE:  o_eval.hit = (i_state == rrtt_pkg::ST_READY)
                                             || (i_state == rrtt_pkg::ST_RUNNING)
                                             || (i_state == rrtt_pkg::ST_BLOCKED);
            default:               o_eval.hit = 1'b0;
        endcase
    end

endmodule

@@ hdl/round_robin_task_table_core.sv @@
// Round-robin task table: sequencer walks the slot table one slot per cycle.
// Per request: a slot scan and/or a round-robin pick over slots in use, then
// an alive count. One item at a time through one compare unit; a new request
// is taken only once the last result has left S_DONE.
// Synchronous active-low reset: slot 0 running with pid 1, all else unused.
// Depends on rrtt_pkg and rrtt_slot_eval.
module round_robin_task_table_core #(
    parameter int MAX_TASKS = 32,
    parameter int PID_BITS  = 16,
    localparam int SLOT_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    localparam int CNT_W    = $clog2(MAX_TASKS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [rrtt_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_func,
    input  logic [PID_BITS-1:0]               i_given_parent,
    input  logic signed [rrtt_pkg::EXIT_W-1:0] i_exit_value,
    input  logic                              i_alloc_ok,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [rrtt_pkg::STATUS_W-1:0]     o_status,
    output logic [PID_BITS-1:0]               o_result_pid,
    output logic signed [rrtt_pkg::EXIT_W-1:0] o_child_code,
    output logic [SLOT_W-1:0]                 o_running_slot,
    output logic [PID_BITS-1:0]               o_running_pid,
    output logic                              o_switched,
    output logic                              o_resched_pending,
    output logic [CNT_W-1:0]                  o_alive_tasks
);

    // table storage
    rrtt_pkg::t_slot_state r_slot_state [MAX_TASKS];
    logic [PID_BITS-1:0]   r_slot_pid    [MAX_TASKS];
    logic [PID_BITS-1:0]   r_slot_parent [MAX_TASKS];
    logic                  r_slot_user   [MAX_TASKS];
    logic [rrtt_pkg::EXIT_W-1:0] r_slot_exit [MAX_TASKS];
    logic                  r_init0;

    rrtt_pkg::t_seq_state r_state, n_state;

    logic                  r_pe, r_flag, n_flag;
    logic [rrtt_pkg::SLICE_W-1:0] r_quantum, r_slice, n_slice;
    logic [PID_BITS-1:0]   r_pid_ctr, n_pid_ctr;
    logic [CNT_W-1:0]      r_siu, n_siu;
    logic [SLOT_W-1:0]     r_cur, n_cur, r_before, n_before;
    logic [PID_BITS-1:0]   r_cur_pid, n_cur_pid, r_cur_parent, n_cur_parent;
    logic                  r_cur_user, n_cur_user;

    rrtt_pkg::t_func       r_func, n_func;
    logic [PID_BITS-1:0]   r_given_parent, n_given_parent;
    logic [rrtt_pkg::EXIT_W-1:0] r_exit_value, n_exit_value;
    logic                  r_alloc_ok, n_alloc_ok;

    rrtt_pkg::t_status     r_status, n_status, r_ok_status, n_ok_status;
    logic [PID_BITS-1:0]   r_rpid, n_rpid;
    logic [rrtt_pkg::EXIT_W-1:0] r_code, n_code;
    logic [SLOT_W-1:0]     r_idx, n_idx, r_next, n_next;
    logic [CNT_W-1:0]      r_step, n_step, r_alive, n_alive;
    logic                  r_any, n_any;

    logic                  r_o_valid;
    logic [rrtt_pkg::STATUS_W-1:0] r_o_status;
    logic [PID_BITS-1:0]   r_o_rpid, r_o_run_pid;
    logic [rrtt_pkg::EXIT_W-1:0] r_o_code;
    logic [SLOT_W-1:0]     r_o_slot;
    logic                  r_o_switched, r_o_resched;
    logic [CNT_W-1:0]      r_o_alive;

    // write port
    logic                  wr_state_en, wr_fields_en, wr_exit_en;
    logic [SLOT_W-1:0]     wr_idx;
    rrtt_pkg::t_slot_state wr_state;
    logic [PID_BITS-1:0]   wr_pid, wr_parent;
    logic                  wr_user;

    // read port at r_idx
    rrtt_pkg::t_slot_state rd_state;
    logic [PID_BITS-1:0]   rd_pid, rd_parent, eval_key;
    logic                  rd_user;
    rrtt_pkg::t_scan_mode  eval_mode;
    rrtt_pkg::t_eval       ev;

    logic                  accept, out_free, idx_last;
    logic [CNT_W-1:0]      idx_ext;
    logic [SLOT_W-1:0]     idx_inc, idx_wrap, cur_wrap;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign idx_ext  = CNT_W'(r_idx);
    assign idx_inc  = r_idx + SLOT_W'(1);
    assign idx_last = (idx_ext + CNT_W'(1)) == r_siu;
    assign idx_wrap = idx_last ? '0 : idx_inc;
    assign cur_wrap = ((CNT_W'(r_cur) + CNT_W'(1)) == r_siu) ? '0 : (r_cur + SLOT_W'(1));

    assign rd_state  = r_slot_state[r_idx];
    assign rd_pid    = (r_init0 && r_idx == '0) ? PID_BITS'(1) : r_slot_pid[r_idx];
    assign rd_parent = (r_init0 && r_idx == '0) ? '0 : r_slot_parent[r_idx];
    assign rd_user   = (r_init0 && r_idx == '0) ? 1'b0 : r_slot_user[r_idx];

    always_comb begin
        case (r_state)
            rrtt_pkg::S_SPAWN_SCAN: eval_mode = rrtt_pkg::SCAN_FREE;
            rrtt_pkg::S_EXIT_SCAN:  eval_mode = rrtt_pkg::SCAN_PARENT;
            rrtt_pkg::S_WAIT_SCAN:  eval_mode = rrtt_pkg::SCAN_CHILD;
            rrtt_pkg::S_PICK:       eval_mode = rrtt_pkg::SCAN_READY;
            default:                eval_mode = rrtt_pkg::SCAN_ALIVE;
        endcase
        eval_key = (r_state == rrtt_pkg::S_EXIT_SCAN) ? r_cur_parent : r_cur_pid;
    end

    rrtt_slot_eval #(
        .PID_BITS (PID_BITS)
    ) u_eval (
        .i_mode   (eval_mode),
        .i_state  (rd_state),
        .i_pid    (rd_pid),
        .i_parent (rd_parent),
        .i_key    (eval_key),
        .o_eval   (ev)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrtt_pkg::S_IDLE: begin
                if (accept) begin
                    case (rrtt_pkg::t_func'(i_func))
                        rrtt_pkg::F_SPAWN_KERNEL,
                        rrtt_pkg::F_SPAWN_USER: n_state = rrtt_pkg::S_SPAWN_SCAN;
                        rrtt_pkg::F_FORK:
                            n_state = i_alloc_ok ? rrtt_pkg::S_SPAWN_SCAN : rrtt_pkg::S_COUNT;
                        rrtt_pkg::F_YIELD:      n_state = rrtt_pkg::S_PICK;
                        rrtt_pkg::F_EXIT:       n_state = rrtt_pkg::S_EXIT_WR;
                        rrtt_pkg::F_WAIT:       n_state = rrtt_pkg::S_WAIT_SCAN;
                        rrtt_pkg::F_IRQ_RETURN:
                            n_state = (r_pe && r_flag) ? rrtt_pkg::S_PICK : rrtt_pkg::S_COUNT;
                        default:                n_state = rrtt_pkg::S_COUNT;
                    endcase
                end
            end
            rrtt_pkg::S_SPAWN_SCAN: begin
                if (ev.hit || r_idx == SLOT_W'(MAX_TASKS - 1)) begin
                    n_state = rrtt_pkg::S_COUNT;
                end
            end
            rrtt_pkg::S_EXIT_WR: n_state = rrtt_pkg::S_EXIT_SCAN;
            rrtt_pkg::S_EXIT_SCAN: begin
                if (ev.hit || idx_last) begin
                    n_state = rrtt_pkg::S_PICK;
                end
            end
            rrtt_pkg::S_WAIT_SCAN: begin
                if (ev.hit && ev.zombie) begin
                    n_state = rrtt_pkg::S_COUNT;
                end else if (idx_last) begin
                    n_state = (r_any || ev.hit) ? rrtt_pkg::S_WAIT_BLOCK : rrtt_pkg::S_COUNT;
                end
            end
            rrtt_pkg::S_WAIT_BLOCK: n_state = rrtt_pkg::S_PICK;
            rrtt_pkg::S_PICK: begin
                if (ev.hit) begin
                    n_state = (r_idx == r_cur) ? rrtt_pkg::S_COUNT : rrtt_pkg::S_MOVE_OUT;
                end else if (r_step == r_siu) begin
                    n_state = rrtt_pkg::S_COUNT;
                end
            end
            rrtt_pkg::S_MOVE_OUT: n_state = rrtt_pkg::S_MOVE_IN;
            rrtt_pkg::S_MOVE_IN:  n_state = rrtt_pkg::S_COUNT;
            rrtt_pkg::S_COUNT: begin
                if (idx_last) begin
                    n_state = rrtt_pkg::S_DONE;
                end
            end
            rrtt_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rrtt_pkg::S_IDLE;
                end
            end
            default: n_state = rrtt_pkg::S_IDLE;
        endcase
    end

    // datapath and table writes
    always_comb begin
        n_flag = r_flag;
        n_slice = r_slice;
        n_pid_ctr = r_pid_ctr;
        n_siu = r_siu;
        n_cur = r_cur;
        n_before = r_before;
        n_cur_pid = r_cur_pid;
        n_cur_parent = r_cur_parent;
        n_cur_user = r_cur_user;
        n_func = r_func;
        n_given_parent = r_given_parent;
        n_exit_value = r_exit_value;
        n_alloc_ok = r_alloc_ok;
        n_status = r_status;
        n_ok_status = r_ok_status;
        n_rpid = r_rpid;
        n_code = r_code;
        n_idx = r_idx;
        n_next = r_next;
        n_step = r_step;
        n_alive = r_alive;
        n_any = r_any;
        wr_state_en = 1'b0;
        wr_fields_en = 1'b0;
        wr_exit_en = 1'b0;
        wr_idx = r_idx;
        wr_state = rrtt_pkg::ST_READY;
        wr_pid = r_pid_ctr;
        wr_parent = (r_func == rrtt_pkg::F_SPAWN_USER) ? r_given_parent : r_cur_pid;
        wr_user = (r_func != rrtt_pkg::F_SPAWN_KERNEL);
        case (r_state)
            rrtt_pkg::S_IDLE: begin
                if (accept) begin
                    n_func = rrtt_pkg::t_func'(i_func);
                    n_given_parent = i_given_parent;
                    n_exit_value = i_exit_value;
                    n_alloc_ok = i_alloc_ok;
                    n_before = r_cur;
                    n_status = rrtt_pkg::RS_OK;
                    n_ok_status = rrtt_pkg::RS_OK;
                    n_rpid = '0;
                    n_code = '0;
                    n_any = 1'b0;
                    n_alive = '0;
                    n_idx = '0;
                    n_step = CNT_W'(1);
                    case (rrtt_pkg::t_func'(i_func))
                        rrtt_pkg::F_FORK: begin
                            if (!i_alloc_ok) begin
                                n_status = rrtt_pkg::RS_ALLOC_FAIL;
                            end
                        end
                        rrtt_pkg::F_YIELD: n_idx = cur_wrap;
                        rrtt_pkg::F_TICK: begin
                            if (r_pe) begin
                                n_slice = (r_slice != '0) ? r_slice - 1'b1 : '0;
                                if (n_slice == '0) begin
                                    n_flag = 1'b1;
                                end
                            end
                        end
                        rrtt_pkg::F_IRQ_RETURN: begin
                            if (r_pe && r_flag) begin
                                n_flag = 1'b0;
                                n_idx = cur_wrap;
                            end
                        end
                        default: n_idx = '0;
                    endcase
                end
            end
            rrtt_pkg::S_SPAWN_SCAN: begin
                if (ev.hit) begin
                    if (idx_ext >= r_siu) begin
                        n_siu = idx_ext + CNT_W'(1);
                    end
                    if (!r_alloc_ok) begin
                        n_status = rrtt_pkg::RS_ALLOC_FAIL;
                    end else begin
                        wr_state_en = 1'b1;
                        wr_fields_en = 1'b1;
                        n_rpid = r_pid_ctr;
                        n_pid_ctr = r_pid_ctr + PID_BITS'(1);
                        // a reaped current slot can be refilled
                        if (r_idx == r_cur) begin
                            n_cur_pid = r_pid_ctr;
                            n_cur_parent = wr_parent;
                            n_cur_user = wr_user;
                        end
                    end
                    n_idx = '0;
                end else if (r_idx == SLOT_W'(MAX_TASKS - 1)) begin
                    n_status = rrtt_pkg::RS_NO_SLOT;
                    n_idx = '0;
                end else begin
                    n_idx = idx_inc;
                end
            end
            rrtt_pkg::S_EXIT_WR: begin
                wr_idx = r_cur;
                wr_exit_en = 1'b1;
                wr_state_en = 1'b1;
                wr_state = r_cur_user ? rrtt_pkg::ST_ZOMBIE : rrtt_pkg::ST_DEAD;
                n_idx = '0;
            end
            rrtt_pkg::S_EXIT_SCAN: begin
                if (ev.hit && ev.blocked) begin
                    wr_state_en = 1'b1;
                end
                if (ev.hit || idx_last) begin
                    n_idx = cur_wrap;
                end else begin
                    n_idx = idx_inc;
                end
            end
            rrtt_pkg::S_WAIT_SCAN: begin
                if (ev.hit) begin
                    n_any = 1'b1;
                end
                if (ev.hit && ev.zombie) begin
                    n_rpid = rd_pid;
                    n_code = r_slot_exit[r_idx];
                    wr_state_en = 1'b1;
                    wr_state = rrtt_pkg::ST_UNUSED;
                    n_idx = '0;
                end else if (idx_last) begin
                    if (!(r_any || ev.hit)) begin
                        n_status = rrtt_pkg::RS_NO_CHILD;
                    end
                    n_idx = '0;
                end else begin
                    n_idx = idx_inc;
                end
            end
            rrtt_pkg::S_WAIT_BLOCK: begin
                wr_idx = r_cur;
                wr_state_en = 1'b1;
                wr_state = rrtt_pkg::ST_BLOCKED;
                n_ok_status = rrtt_pkg::RS_BLOCKED;
                n_idx = cur_wrap;
                n_step = CNT_W'(1);
            end
            rrtt_pkg::S_PICK: begin
                if (ev.hit) begin
                    n_status = r_ok_status;
                    n_next = r_idx;
                    n_idx = (r_idx == r_cur) ? '0 : r_cur;
                end else if (r_step == r_siu) begin
                    // last probe is the current slot itself
                    n_status = ev.live ? r_ok_status : rrtt_pkg::RS_NOTHING_RUN;
                    n_idx = '0;
                end else begin
                    n_idx = idx_wrap;
                    n_step = r_step + CNT_W'(1);
                end
            end
            rrtt_pkg::S_MOVE_OUT: begin
                if (rd_state == rrtt_pkg::ST_RUNNING) begin
                    wr_state_en = 1'b1;
                end
                n_idx = r_next;
            end
            rrtt_pkg::S_MOVE_IN: begin
                wr_state_en = 1'b1;
                wr_state = rrtt_pkg::ST_RUNNING;
                n_cur = r_idx;
                n_cur_pid = rd_pid;
                n_cur_parent = rd_parent;
                n_cur_user = rd_user;
                n_slice = r_quantum;
                n_idx = '0;
            end
            rrtt_pkg::S_COUNT: begin
                n_alive = r_alive + CNT_W'(ev.hit);
                n_idx = idx_last ? '0 : idx_inc;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    assign o_stall = (r_state != rrtt_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrtt_pkg::S_IDLE;
            r_pe <= 1'b0;
            r_quantum <= rrtt_pkg::SLICE_W'(1);
            r_flag <= 1'b0;
            r_slice <= rrtt_pkg::SLICE_W'(1);
            r_pid_ctr <= PID_BITS'(2);
            r_siu <= CNT_W'(1);
            r_cur <= '0;
            r_cur_pid <= PID_BITS'(1);
            r_cur_parent <= '0;
            r_cur_user <= 1'b0;
            r_init0 <= 1'b1;
            r_o_valid <= 1'b0;
            for (int k = 0; k < MAX_TASKS; k++) begin
                r_slot_state[k] <= (k == 0) ? rrtt_pkg::ST_RUNNING : rrtt_pkg::ST_UNUSED;
            end
        end else begin
            r_state <= n_state;
            r_flag <= n_flag;
            r_slice <= n_slice;
            r_pid_ctr <= n_pid_ctr;
            r_siu <= n_siu;
            r_cur <= n_cur;
            r_cur_pid <= n_cur_pid;
            r_cur_parent <= n_cur_parent;
            r_cur_user <= n_cur_user;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rrtt_pkg::CFG_PREEMPT: r_pe <= i_cfg_data[0];
                    rrtt_pkg::CFG_QUANTUM: r_quantum <= i_cfg_data;
                    default:               r_pe <= r_pe;
                endcase
            end
            if (wr_state_en) begin
                r_slot_state[wr_idx] <= wr_state;
            end
            if (wr_fields_en && wr_idx == '0) begin
                r_init0 <= 1'b0;
            end
            if (r_state == rrtt_pkg::S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers and table fields
    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_given_parent <= n_given_parent;
        r_exit_value <= n_exit_value;
        r_alloc_ok <= n_alloc_ok;
        r_before <= n_before;
        r_status <= n_status;
        r_ok_status <= n_ok_status;
        r_rpid <= n_rpid;
        r_code <= n_code;
        r_idx <= n_idx;
        r_next <= n_next;
        r_step <= n_step;
        r_alive <= n_alive;
        r_any <= n_any;
        if (wr_fields_en) begin
            r_slot_pid[wr_idx] <= wr_pid;
            r_slot_parent[wr_idx] <= wr_parent;
            r_slot_user[wr_idx] <= wr_user;
        end
        if (wr_exit_en) begin
            r_slot_exit[wr_idx] <= r_exit_value;
        end
        if (r_state == rrtt_pkg::S_DONE && out_free) begin
            r_o_status <= r_status;
            r_o_rpid <= r_rpid;
            r_o_code <= r_code;
            r_o_slot <= r_cur;
            r_o_run_pid <= r_cur_pid;
            r_o_switched <= (r_cur != r_before);
            r_o_resched <= r_flag;
            r_o_alive <= r_alive;
        end
    end

    assign o_valid = r_o_valid;
    assign o_status = r_o_status;
    assign o_result_pid = r_o_rpid;
    assign o_child_code = r_o_code;
    assign o_running_slot = r_o_slot;
    assign o_running_pid = r_o_run_pid;
    assign o_switched = r_o_switched;
    assign o_resched_pending = r_o_resched;
    assign o_alive_tasks = r_o_alive;

`ifndef NO_ASSERTIONS
    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_cur) < r_siu)
        else $error("current slot outside slots in use");

    a_alive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_alive <= r_siu))
        else $error("alive count exceeds slots in use");

    a_pid_only_on_spawn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pid_ctr != $past(r_pid_ctr)) |-> ($past(r_state) == rrtt_pkg::S_SPAWN_SCAN))
        else $error("pid counter moved outside a spawn");
`endif

endmodule

@@ tb/sv/round_robin_task_table_core_tb.sv @@
// Testbench for round_robin_task_table_core: random and directed scheduler requests,
// checked result by result against an in-bench model of the task table.
// Depends on rrtt_pkg and the core RTL.
module round_robin_task_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 32;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        rrtt_pkg::t_func func;
        logic [15:0]     parent;
        logic [31:0]     exitv;
        logic            alloc;
    } req_t;

    typedef struct {
        rrtt_pkg::t_status status;
        logic [15:0]       rpid;
        logic [31:0]       code;
        logic [4:0]        rslot;
        logic [15:0]       run_pid;
        logic              sw;
        logic              resched;
        logic [5:0]        alive;
    } resp_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_func = '0;
    logic [15:0] i_given_parent = '0;
    logic signed [31:0] i_exit_value = '0;
    logic        i_alloc_ok = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_result_pid;
    logic signed [31:0] o_child_code;
    logic [4:0]  o_running_slot;
    logic [15:0] o_running_pid;
    logic        o_switched;
    logic        o_resched_pending;
    logic [5:0]  o_alive_tasks;

    round_robin_task_table_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // task table model
    rrtt_pkg::t_slot_state tbl_state[NSLOT];
    logic [15:0] tbl_pid[NSLOT];
    logic [15:0] tbl_parent[NSLOT];
    bit          tbl_user[NSLOT];
    logic [31:0] tbl_exit[NSLOT];
    int          in_use, cur_slot, slice_left;
    logic [15:0] pid_next;
    bit          resched, preempt_on;
    logic [7:0]  quantum;

    req_t  pending[$];
    resp_t expected[$];
    int    errors = 0;
    int    cycles = 0;

    task automatic model_reset();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_state[i] = rrtt_pkg::ST_UNUSED;
            tbl_pid[i] = '0;
            tbl_parent[i] = '0;
            tbl_user[i] = 0;
            tbl_exit[i] = '0;
        end
        tbl_state[0] = rrtt_pkg::ST_RUNNING;
        tbl_pid[0] = 16'd1;
        in_use = 1;
        cur_slot = 0;
        pid_next = 16'd2;
        slice_left = 1;
        resched = 0;
        preempt_on = 0;
        quantum = 8'd1;
    endtask

    // round-robin pick, falls back to the current slot
    task automatic reschedule(input rrtt_pkg::t_status ok_status,
                              output rrtt_pkg::t_status st);
        int nxt;
        bit found;
        nxt = cur_slot;
        found = 0;
        for (int s = 1; s <= in_use; s++) begin
            if (!found && tbl_state[(cur_slot + s) % in_use] == rrtt_pkg::ST_READY) begin
                nxt = (cur_slot + s) % in_use;
                found = 1;
            end
        end
        if (!found && tbl_state[cur_slot] != rrtt_pkg::ST_RUNNING
                && tbl_state[cur_slot] != rrtt_pkg::ST_READY) begin
            st = rrtt_pkg::RS_NOTHING_RUN;
            return;
        end
        if (nxt != cur_slot) begin
            if (tbl_state[cur_slot] == rrtt_pkg::ST_RUNNING)
                tbl_state[cur_slot] = rrtt_pkg::ST_READY;
            tbl_state[nxt] = rrtt_pkg::ST_RUNNING;
            cur_slot = nxt;
            slice_left = quantum;
        end
        st = ok_status;
    endtask

    task automatic create_task(input logic [15:0] par, input bit user, input bit ok,
                               output rrtt_pkg::t_status st, output logic [15:0] npid);
        int fs;
        fs = -1;
        npid = '0;
        for (int i = NSLOT - 1; i >= 0; i--)
            if (tbl_state[i] == rrtt_pkg::ST_UNUSED)
                fs = i;
        if (fs < 0) begin
            st = rrtt_pkg::RS_NO_SLOT;
            return;
        end
        if (fs >= in_use)
            in_use = fs + 1;
        if (!ok) begin
            st = rrtt_pkg::RS_ALLOC_FAIL;
            return;
        end
        tbl_pid[fs] = pid_next;
        pid_next = pid_next + 16'd1;
        tbl_parent[fs] = par;
        tbl_state[fs] = rrtt_pkg::ST_READY;
        tbl_user[fs] = user;
        npid = tbl_pid[fs];
        st = rrtt_pkg::RS_OK;
    endtask

    task automatic predict_step(input req_t r, output resp_t o);
        int prev_slot;
        logic [15:0] me;
        bit any, reaped, done;
        rrtt_pkg::t_status st;
        prev_slot = cur_slot;
        me = tbl_pid[cur_slot];
        o = '{rrtt_pkg::RS_OK, 16'd0, 32'd0, 5'd0, 16'd0, 1'b0, 1'b0, 6'd0};
        st = rrtt_pkg::RS_OK;
        case (r.func)
            rrtt_pkg::F_SPAWN_KERNEL: create_task(me, 0, r.alloc, st, o.rpid);
            rrtt_pkg::F_SPAWN_USER:   create_task(r.parent, 1, r.alloc, st, o.rpid);
            rrtt_pkg::F_FORK: begin
                if (!r.alloc)
                    st = rrtt_pkg::RS_ALLOC_FAIL;
                else
                    create_task(me, 1, 1, st, o.rpid);
            end
            rrtt_pkg::F_YIELD: reschedule(rrtt_pkg::RS_OK, st);
            rrtt_pkg::F_EXIT: begin
                tbl_exit[cur_slot] = r.exitv;
                tbl_state[cur_slot] = tbl_user[cur_slot] ? rrtt_pkg::ST_ZOMBIE
                                                         : rrtt_pkg::ST_DEAD;
                done = 0;
                for (int i = 0; i < in_use; i++) begin
                    if (!done && tbl_state[i] != rrtt_pkg::ST_UNUSED
                            && tbl_pid[i] == tbl_parent[cur_slot]) begin
                        if (tbl_state[i] == rrtt_pkg::ST_BLOCKED)
                            tbl_state[i] = rrtt_pkg::ST_READY;
                        done = 1;
                    end
                end
                reschedule(rrtt_pkg::RS_OK, st);
            end
            rrtt_pkg::F_WAIT: begin
                any = 0;
                reaped = 0;
                for (int i = 0; i < in_use; i++) begin
                    if (!reaped && tbl_state[i] != rrtt_pkg::ST_UNUSED
                            && tbl_parent[i] == me) begin
                        any = 1;
                        if (tbl_state[i] == rrtt_pkg::ST_ZOMBIE) begin
                            o.rpid = tbl_pid[i];
                            o.code = tbl_exit[i];
                            tbl_state[i] = rrtt_pkg::ST_UNUSED;
                            reaped = 1;
                        end
                    end
                end
                if (!reaped) begin
                    if (!any)
                        st = rrtt_pkg::RS_NO_CHILD;
                    else begin
                        tbl_state[cur_slot] = rrtt_pkg::ST_BLOCKED;
                        reschedule(rrtt_pkg::RS_BLOCKED, st);
                    end
                end
            end
            rrtt_pkg::F_TICK: begin
                if (preempt_on) begin
                    if (slice_left > 0)
                        slice_left--;
                    if (slice_left == 0)
                        resched = 1;
                end
            end
            default: begin
                if (preempt_on && resched) begin
                    resched = 0;
                    reschedule(rrtt_pkg::RS_OK, st);
                end
            end
        endcase
        o.status = st;
        for (int i = 0; i < in_use; i++)
            if (tbl_state[i] inside {rrtt_pkg::ST_READY, rrtt_pkg::ST_RUNNING,
                                     rrtt_pkg::ST_BLOCKED})
                o.alive++;
        o.rslot = cur_slot[4:0];
        o.run_pid = tbl_pid[cur_slot];
        o.sw = (cur_slot != prev_slot);
        o.resched = resched;
    endtask

    task automatic report(input string fld, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("%0t: %s got 0x%0h, want 0x%0h", $realtime, fld, got, want);
    endtask

    // sender
    int  gap_left = 0;
    bit  no_gaps = 0;
    always @(posedge i_clk) begin
        req_t  r;
        resp_t e;
        bit    load;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            load = 0;
            if (i_valid && !o_stall) begin
                r = '{rrtt_pkg::t_func'(i_func), i_given_parent, i_exit_value, i_alloc_ok};
                predict_step(r, e);
                expected.push_back(e);
                if ($urandom_range(0, 40) == 0)
                    no_gaps = ~no_gaps;
                gap_left = no_gaps ? 0 : $urandom_range(0, 16);
                load = (gap_left == 0);
            end else if (!i_valid) begin
                if (gap_left > 0)
                    gap_left--;
                else
                    load = 1;
            end
            if (load && pending.size() > 0) begin
                r = pending.pop_front();
                i_func <= r.func;
                i_given_parent <= r.parent;
                i_exit_value <= r.exitv;
                i_alloc_ok <= r.alloc;
                i_valid <= 1'b1;
            end else if (load) begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    int stall_left = 0;
    always @(posedge i_clk) begin
        resp_t e;
        if (o_valid && !i_stall) begin
            if (expected.size() == 0) begin
                report("unexpected item", 0, 0);
            end else begin
                e = expected.pop_front();
                if (o_status !== e.status)       report("status", o_status, e.status);
                if (o_result_pid !== e.rpid)     report("result_pid", o_result_pid, e.rpid);
                if (o_child_code !== e.code)     report("child_code", o_child_code, e.code);
                if (o_running_slot !== e.rslot)  report("running_slot", o_running_slot, e.rslot);
                if (o_running_pid !== e.run_pid) report("running_pid", o_running_pid, e.run_pid);
                if (o_switched !== e.sw)         report("switched", o_switched, e.sw);
                if (o_resched_pending !== e.resched)
                    report("resched_pending", o_resched_pending, e.resched);
                if (o_alive_tasks !== e.alive)   report("alive_tasks", o_alive_tasks, e.alive);
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, 16);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("round_robin_task_table_core: mismatch");
            $finish;
        end
    end

    task automatic add(input rrtt_pkg::t_func f, input logic [15:0] p, input logic [31:0] x,
                       input logic ok);
        req_t r;
        r = '{f, p, x, ok};
        pending.push_back(r);
    endtask

    task automatic add_random(input int n);
        int w;
        rrtt_pkg::t_func f;
        for (int k = 0; k < n; k++) begin
            w = $urandom_range(0, 99);
            if (w < 3)       f = rrtt_pkg::F_SPAWN_KERNEL;
            else if (w < 13) f = rrtt_pkg::F_SPAWN_USER;
            else if (w < 33) f = rrtt_pkg::F_FORK;
            else if (w < 48) f = rrtt_pkg::F_YIELD;
            else if (w < 63) f = rrtt_pkg::F_EXIT;
            else if (w < 80) f = rrtt_pkg::F_WAIT;
            else if (w < 92) f = rrtt_pkg::F_TICK;
            else             f = rrtt_pkg::F_IRQ_RETURN;
            add(f, ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 64)) : 16'($urandom),
                $urandom, $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic drain();
        while (pending.size() > 0 || i_valid || expected.size() > 0)
            @(posedge i_clk);
        repeat (110) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rrtt_pkg::CFG_PREEMPT)
            preempt_on = val[0];
        else
            quantum = val;
    endtask

    initial begin
        model_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: failures, extremes of every field, each request kind
        add(rrtt_pkg::F_SPAWN_KERNEL, 16'h0000, 32'h0, 1'b0);
        add(rrtt_pkg::F_SPAWN_KERNEL, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        add(rrtt_pkg::F_SPAWN_USER, 16'hFFFF, 32'h0, 1'b1);
        add(rrtt_pkg::F_SPAWN_USER, 16'h0000, 32'h0, 1'b1);
        add(rrtt_pkg::F_FORK, 16'h0, 32'h0, 1'b0);
        add(rrtt_pkg::F_FORK, 16'h0, 32'h0, 1'b1);
        add(rrtt_pkg::F_WAIT, 16'h0, 32'h0, 1'b1);
        add(rrtt_pkg::F_YIELD, 16'h0, 32'h0, 1'b1);
        add(rrtt_pkg::F_EXIT, 16'h0, 32'h8000_0000, 1'b1);
        add(rrtt_pkg::F_YIELD, 16'h0, 32'h0, 1'b1);
        add(rrtt_pkg::F_EXIT, 16'h0, 32'h7FFF_FFFF, 1'b1);
        add(rrtt_pkg::F_WAIT, 16'h0, 32'h0, 1'b1);
        add(rrtt_pkg::F_TICK, 16'h0, 32'h0, 1'b1);
        add(rrtt_pkg::F_IRQ_RETURN, 16'h0, 32'h0, 1'b1);
        add(rrtt_pkg::F_WAIT, 16'h0, 32'h0, 1'b1);
        add(rrtt_pkg::F_EXIT, 16'h0, 32'hFFFF_FFFF, 1'b0);
        add(rrtt_pkg::F_YIELD, 16'h0, 32'h0, 1'b0);
        add(rrtt_pkg::F_WAIT, 16'h0, 32'h0, 1'b0);
        add_random(150);
        drain();

        // quantum zero requests a reschedule on the very next tick
        write_cfg(rrtt_pkg::CFG_PREEMPT, 8'd1);
        write_cfg(rrtt_pkg::CFG_QUANTUM, 8'd0);
        add(rrtt_pkg::F_TICK, 16'h0, 32'h0, 1'b1);
        add(rrtt_pkg::F_IRQ_RETURN, 16'h0, 32'h0, 1'b1);
        add(rrtt_pkg::F_IRQ_RETURN, 16'h0, 32'h0, 1'b1);
        add_random(150);
        drain();

        write_cfg(rrtt_pkg::CFG_QUANTUM, 8'd1);
        add_random(150);
        drain();

        write_cfg(rrtt_pkg::CFG_QUANTUM, 8'd255);
        add_random(150);
        drain();

        write_cfg(rrtt_pkg::CFG_QUANTUM, 8'd3);
        add_random(150);
        drain();

        write_cfg(rrtt_pkg::CFG_PREEMPT, 8'd0);
        write_cfg(rrtt_pkg::CFG_QUANTUM, 8'd128);
        add_random(150);
        drain();

        if (errors == 0)
            $display("round_robin_task_table_core: match");
        else
            $display("round_robin_task_table_core: mismatch");
        $finish;
    end
endmodule

@@ files.f @@
hdl/rrtt_pkg.sv
hdl/rrtt_slot_eval.sv
hdl/round_robin_task_table_core.sv
tb/sv/round_robin_task_table_core_tb.sv
